/* hdl/xsfu_pkg.sv */
// types, codes and helpers shared by the x86 shift and flags unit
`timescale 1ns / 1ps

package xsfu_pkg;

  typedef enum logic [2:0] {
    OP_SHL  = 3'd0,
    OP_SHR  = 3'd1,
    OP_SAR  = 3'd2,
    OP_SHLD = 3'd3,
    OP_SHRD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2,
    SZ_64 = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    CF_ZERO  = 2'd0,
    CF_LEFT  = 2'd1,
    CF_RIGHT = 2'd2
  } cf_mode_e;

  typedef enum logic [1:0] {
    OF_ZERO = 2'd0,
    OF_ONE  = 2'd1,
    OF_VMSB = 2'd2,
    OF_XOR  = 2'd3
  } of_mode_e;

  typedef struct packed {
    size_e    size;
    logic     flags_wr;
    logic     flags_clr;
    cf_mode_e cf_mode;
    of_mode_e of_mode;
    logic     sf_zero;
    logic     vmsb;
  } ctrl_t;

  typedef struct packed {
    logic wr;
    logic cf;
    logic pf;
    logic af;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  function automatic logic [63:0] size_mask(input size_e size);
    logic [63:0] m;
    unique case (size)
      SZ_8:    m = 64'h0000_0000_0000_00FF;
      SZ_16:   m = 64'h0000_0000_0000_FFFF;
      SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* hdl/x86_shift_flags_unit.sv */
// top level of the x86 shift unit: four register stages, one beat per cycle
`timescale 1ns / 1ps

// takes one shift beat every cycle; busy_o stays low. each beat gives exactly one result,
// strobed on valid_o after passing the register stages in order: decode and funnel setup,
// byte-granular shift, bit-granular shift with carry pick, then flag logic and the
// output register. the receiver cannot stall, so results must be taken when strobed.
module x86_shift_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] value_i,
  input  logic [63:0] fill_value_i,
  input  logic [7:0]  shift_count_i,
  output logic        valid_o,
  output logic [63:0] result_o,
  output logic        flags_written_o,
  output logic        carry_flag_o,
  output logic        parity_flag_o,
  output logic        aux_flag_o,
  output logic        zero_flag_o,
  output logic        sign_flag_o,
  output logic        overflow_flag_o
);

  logic             accept;
  logic [127:0]     funnel_d;
  logic [6:0]       amt_d;
  xsfu_pkg::ctrl_t  ctrl_d;

  logic             v1_q, v2_q, v3_q, v4_q;
  logic [127:0]     funnel_q;
  logic [6:0]       amt1_q;
  xsfu_pkg::ctrl_t  ctrl1_q;

  logic [72:0]      coarse_d, coarse_q;
  logic [2:0]       amt2_q;
  xsfu_pkg::ctrl_t  ctrl2_q;

  logic [72:0]      fine;
  logic [65:0]      z;
  logic [63:0]      res_d, res3_q;
  logic             cf_d, cf3_q;
  xsfu_pkg::ctrl_t  ctrl3_q;

  xsfu_pkg::flags_t flags_d, flags_q;
  logic [63:0]      result_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  xsfu_decode u_decode (
    .operation_i  (operation_i),
    .size_code_i  (size_code_i),
    .value_i      (value_i),
    .fill_value_i (fill_value_i),
    .shift_count_i(shift_count_i),
    .funnel_o     (funnel_d),
    .amt_o        (amt_d),
    .ctrl_o       (ctrl_d)
  );

  // byte step, with a guard bit below for the right-shift carry
  assign coarse_d = 73'({funnel_q, 1'b0} >> {amt1_q[6:3], 3'b000});

  // bit step
  assign fine  = coarse_q >> amt2_q;
  assign z     = fine[65:0];
  assign res_d = z[64:1] & xsfu_pkg::size_mask(ctrl2_q.size);

  always_comb begin
    unique case (ctrl2_q.cf_mode)
      xsfu_pkg::CF_RIGHT: cf_d = z[0];
      xsfu_pkg::CF_LEFT: begin
        unique case (ctrl2_q.size)
          xsfu_pkg::SZ_8:  cf_d = z[9];
          xsfu_pkg::SZ_16: cf_d = z[17];
          xsfu_pkg::SZ_32: cf_d = z[33];
          default:         cf_d = z[65];
        endcase
      end
      default: cf_d = 1'b0;
    endcase
  end

  xsfu_flags u_flags (
    .result_i(res3_q),
    .carry_i (cf3_q),
    .ctrl_i  (ctrl3_q),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      funnel_q <= funnel_d;
      amt1_q   <= amt_d;
      ctrl1_q  <= ctrl_d;
    end
    if (v1_q) begin
      coarse_q <= coarse_d;
      amt2_q   <= amt1_q[2:0];
      ctrl2_q  <= ctrl1_q;
    end
    if (v2_q) begin
      res3_q  <= res_d;
      cf3_q   <= cf_d;
      ctrl3_q <= ctrl2_q;
    end
    if (v3_q) begin
      result_q <= res3_q;
      flags_q  <= flags_d;
    end
  end

  assign valid_o         = v4_q;
  assign result_o        = result_q;
  assign flags_written_o = flags_q.wr;
  assign carry_flag_o    = flags_q.cf;
  assign parity_flag_o   = flags_q.pf;
  assign aux_flag_o      = flags_q.af;
  assign zero_flag_o     = flags_q.zf;
  assign sign_flag_o     = flags_q.sf;
  assign overflow_flag_o = flags_q.of;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("accepted beat did not produce a result after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 4))
    else $error("result strobe without a matching accepted beat");

  a_zero_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_flag_o) |-> (!sign_flag_o && parity_flag_o && flags_written_o))
    else $error("zero flag inconsistent with sign or parity flag");

  a_clear_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !flags_written_o) |->
      !(carry_flag_o || parity_flag_o || zero_flag_o || sign_flag_o || overflow_flag_o))
    else $error("flags set on a beat that writes no flags");

endmodule

/* hdl/xsfu_decode.sv */
// operand masking, count decode and funnel setup for the shift unit
`timescale 1ns / 1ps

module xsfu_decode (
  input  logic [2:0]     operation_i,
  input  logic [1:0]     size_code_i,
  input  logic [63:0]    value_i,
  input  logic [63:0]    fill_value_i,
  input  logic [7:0]     shift_count_i,
  output logic [127:0]   funnel_o,
  output logic [6:0]     amt_o,
  output xsfu_pkg::ctrl_t ctrl_o
);

  xsfu_pkg::size_e size;
  logic [63:0]     mask;
  logic [6:0]      width;
  logic [6:0]      cnt;
  logic [63:0]     v;
  logic [63:0]     f;
  logic [63:0]     sign_fill;
  logic            vmsb;
  logic [63:0]     hi;
  logic [63:0]     lo;

  assign size = xsfu_pkg::size_e'(size_code_i);
  assign mask = xsfu_pkg::size_mask(size);
  assign v    = value_i & mask;
  assign f    = fill_value_i & mask;

  always_comb begin
    unique case (size)
      xsfu_pkg::SZ_8: begin
        width = 7'd8;
        cnt   = {2'b00, shift_count_i[4:0]};
        vmsb  = value_i[7];
      end
      xsfu_pkg::SZ_16: begin
        width = 7'd16;
        cnt   = {2'b00, shift_count_i[4:0]};
        vmsb  = value_i[15];
      end
      xsfu_pkg::SZ_32: begin
        width = 7'd32;
        cnt   = {2'b00, shift_count_i[4:0]};
        vmsb  = value_i[31];
      end
      default: begin
        width = 7'd64;
        cnt   = {1'b0, shift_count_i[5:0]};
        vmsb  = value_i[63];
      end
    endcase
  end

  assign sign_fill = vmsb ? mask : 64'd0;

  always_comb begin
    hi                = 64'd0;
    lo                = v;
    amt_o             = 7'd0;
    ctrl_o.size       = size;
    ctrl_o.flags_wr   = 1'b0;
    ctrl_o.flags_clr  = 1'b1;
    ctrl_o.cf_mode    = xsfu_pkg::CF_ZERO;
    ctrl_o.of_mode    = xsfu_pkg::OF_ZERO;
    ctrl_o.sf_zero    = 1'b0;
    ctrl_o.vmsb       = vmsb;
    if (cnt != 7'd0) begin
      unique case (xsfu_pkg::op_e'(operation_i))
        xsfu_pkg::OP_SHL: begin
          ctrl_o.flags_wr  = 1'b1;
          ctrl_o.flags_clr = 1'b0;
          if (cnt >= width) begin
            lo             = 64'd0;
            ctrl_o.of_mode = xsfu_pkg::OF_ONE;
          end else begin
            hi             = v;
            lo             = 64'd0;
            amt_o          = width - cnt;
            ctrl_o.cf_mode = xsfu_pkg::CF_LEFT;
            ctrl_o.of_mode = (cnt == 7'd1) ? xsfu_pkg::OF_XOR : xsfu_pkg::OF_ZERO;
          end
        end
        xsfu_pkg::OP_SHR: begin
          ctrl_o.flags_wr  = 1'b1;
          ctrl_o.flags_clr = 1'b0;
          ctrl_o.sf_zero   = 1'b1;
          if (cnt >= width) begin
            lo = 64'd0;
          end else begin
            amt_o          = cnt;
            ctrl_o.cf_mode = xsfu_pkg::CF_RIGHT;
            ctrl_o.of_mode = (cnt == 7'd1) ? xsfu_pkg::OF_VMSB : xsfu_pkg::OF_ZERO;
          end
        end
        xsfu_pkg::OP_SAR: begin
          ctrl_o.flags_wr  = 1'b1;
          ctrl_o.flags_clr = 1'b0;
          if (cnt >= width) begin
            lo = sign_fill;
          end else begin
            hi             = sign_fill;
            amt_o          = cnt;
            ctrl_o.cf_mode = xsfu_pkg::CF_RIGHT;
          end
        end
        xsfu_pkg::OP_SHLD: begin
          ctrl_o.flags_wr = 1'b1;
          if (cnt <= width) begin
            ctrl_o.flags_clr = 1'b0;
            hi               = v;
            lo               = f;
            amt_o            = width - cnt;
            ctrl_o.cf_mode   = xsfu_pkg::CF_LEFT;
            ctrl_o.of_mode   = xsfu_pkg::OF_XOR;
          end
        end
        xsfu_pkg::OP_SHRD: begin
          ctrl_o.flags_wr = 1'b1;
          if (cnt <= width) begin
            ctrl_o.flags_clr = 1'b0;
            hi               = f;
            amt_o            = cnt;
            ctrl_o.cf_mode   = xsfu_pkg::CF_RIGHT;
            ctrl_o.of_mode   = xsfu_pkg::OF_XOR;
          end
        end
        default: begin
          hi = 64'd0;
        end
      endcase
    end
  end

  assign funnel_o = {64'd0, lo} | ({64'd0, hi} << width);

endmodule

/* hdl/xsfu_flags.sv */
// status flag generation from the shifted result
`timescale 1ns / 1ps

module xsfu_flags (
  input  logic [63:0]      result_i,
  input  logic             carry_i,
  input  xsfu_pkg::ctrl_t  ctrl_i,
  output xsfu_pkg::flags_t flags_o
);

  logic res_msb;
  logic of_raw;

  always_comb begin
    unique case (ctrl_i.size)
      xsfu_pkg::SZ_8:  res_msb = result_i[7];
      xsfu_pkg::SZ_16: res_msb = result_i[15];
      xsfu_pkg::SZ_32: res_msb = result_i[31];
      default:         res_msb = result_i[63];
    endcase
  end

  always_comb begin
    unique case (ctrl_i.of_mode)
      xsfu_pkg::OF_ONE:  of_raw = 1'b1;
      xsfu_pkg::OF_VMSB: of_raw = ctrl_i.vmsb;
      xsfu_pkg::OF_XOR:  of_raw = ctrl_i.vmsb ^ res_msb;
      default:           of_raw = 1'b0;
    endcase
  end

  always_comb begin
    flags_o.wr = ctrl_i.flags_wr;
    flags_o.af = 1'b0;
    if (ctrl_i.flags_clr) begin
      flags_o.cf = 1'b0;
      flags_o.pf = 1'b0;
      flags_o.zf = 1'b0;
      flags_o.sf = 1'b0;
      flags_o.of = 1'b0;
    end else begin
      flags_o.cf = carry_i;
      flags_o.pf = ~^result_i[7:0];
      flags_o.zf = (result_i == 64'd0);
      flags_o.sf = ctrl_i.sf_zero ? 1'b0 : res_msb;
      flags_o.of = of_raw;
    end
  end

endmodule
